// ----- design/epnl_pkg.sv -----
//------------------------------------------------------------------------------
// epnl_pkg
// types, constants and helpers shared by the edgel pair neighbor linker
//------------------------------------------------------------------------------
`default_nettype none
package epnl_pkg;

  localparam int MaxEdgelsDefault = 64;
  localparam logic [16:0] ThresholdReset = 17'd52429;
  localparam logic [16:0] ScoreOne = 17'd65536;

  typedef struct packed {
    logic [9:0] scan_line;
    logic [13:0] pos_x;
    logic [12:0] pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic last_edgel;
  } in_item_t;

  typedef struct packed {
    logic [5:0] edgel_index;
    logic pair_valid;
    logic [5:0] pair_left;
    logic [5:0] pair_right;
    logic [16:0] pair_score;
    logic has_left;
    logic [5:0] left_index;
    logic [16:0] left_weight;
    logic has_right;
    logic [5:0] right_index;
    logic [16:0] right_weight;
    logic last_result;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear_links;
    logic clear_step;
    logic rd_pair;
    logic sim_start;
    logic upd_link;
    logic rd_rslt;
    logic [5:0] i;
    logic [5:0] j;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic adjacent;
    logic sim_done;
    logic rslt_ready;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- design/epnl_sim.sv -----
//------------------------------------------------------------------------------
// epnl_sim
// multi-cycle pair similarity: cross products, root and divide, one bit a step
//------------------------------------------------------------------------------
`default_nettype none
module epnl_sim (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic signed [15:0] ax,
  input  wire logic signed [15:0] ay,
  input  wire logic signed [15:0] bx,
  input  wire logic signed [15:0] by,
  input  wire logic signed [14:0] dx,
  input  wire logic signed [13:0] dy,
  output logic done,
  output logic [16:0] score
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_SUM = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_DIV = 3'd4;
  localparam logic [2:0] S_FIN = 3'd5;

  logic [2:0] state;
  logic [5:0] cnt;
  logic signed [32:0] p0, p1, p2, p3, p4, p5;
  logic [29:0] sq0, sq1;
  logic dot_pos, zero_d;
  logic [34:0] csum;
  logic [47:0] rem_n;
  logic [23:0] root;
  logic [25:0] sq_rem;
  logic [45:0] num;
  logic [45:0] quo;
  logic [46:0] drem;

  logic [25:0] sq_trial;
  logic [25:0] sq_shift;
  logic [46:0] d_shift;
  logic signed [33:0] c1s, c2s;
  logic [33:0] c1, c2;

  always_comb begin
    sq_shift = {sq_rem[23:0], rem_n[47:46]};
    sq_trial = {root, 2'b01};
    d_shift = {drem[45:0], num[45]};
    c1s = {p2[32], p2} - {p3[32], p3};
    c2s = {p4[32], p4} - {p5[32], p5};
    c1 = c1s[33] ? 34'(-c1s) : 34'(c1s);
    c2 = c2s[33] ? 34'(-c2s) : 34'(c2s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            p0 <= 33'(ax * bx);
            p1 <= 33'(ay * by);
            p2 <= 33'(ax * dy);
            p3 <= 33'(ay * dx);
            p4 <= 33'(bx * dy);
            p5 <= 33'(by * dx);
            sq0 <= 30'(dx * dx);
            sq1 <= 30'(dy * dy);
            zero_d <= (dx == '0) && (dy == '0);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          dot_pos <= ($signed({p0[32], p0}) + $signed({p1[32], p1})) > 34'sd0;
          csum <= {1'b0, c1} + {1'b0, c2};
          rem_n <= {2'b00, sq0 + sq1, 16'd0};
          state <= S_SUM;
        end
        S_SUM: begin
          root <= '0;
          sq_rem <= '0;
          cnt <= 6'd0;
          num <= {2'b0, csum, 9'd0};
          if (!dot_pos || zero_d) state <= S_FIN;
          else state <= S_SQRT;
        end
        S_SQRT: begin
          rem_n <= {rem_n[45:0], 2'b00};
          if (sq_shift >= sq_trial) begin
            sq_rem <= sq_shift - sq_trial;
            root <= {root[22:0], 1'b1};
          end else begin
            sq_rem <= sq_shift;
            root <= {root[22:0], 1'b0};
          end
          if (cnt == 6'd23) begin
            cnt <= 6'd0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_DIV: begin
          if (cnt == 6'd0) begin
            num <= num + 46'(root[23:1]);
            drem <= '0;
            quo <= '0;
            cnt <= 6'd1;
          end else begin
            num <= {num[44:0], 1'b0};
            if (d_shift >= {23'd0, root}) begin
              drem <= d_shift - {23'd0, root};
              quo <= {quo[44:0], 1'b1};
            end else begin
              drem <= d_shift;
              quo <= {quo[44:0], 1'b0};
            end
            if (cnt == 6'd46) state <= S_FIN;
            cnt <= cnt + 6'd1;
          end
        end
        S_FIN: begin
          if (!dot_pos) score <= '0;
          else if (zero_d) score <= epnl_pkg::ScoreOne;
          else if (quo >= 46'(epnl_pkg::ScoreOne)) score <= '0;
          else score <= epnl_pkg::ScoreOne - 17'(quo);
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/epnl_dp.sv -----
//------------------------------------------------------------------------------
// epnl_dp
// edgel and link stores, similarity unit, link update and result assembly
//------------------------------------------------------------------------------
`default_nettype none
module epnl_dp #(
  parameter int MAX_EDGELS = epnl_pkg::MaxEdgelsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire epnl_pkg::in_item_t in_item,
  input  wire logic [5:0] load_addr,
  input  wire logic [16:0] match_threshold,
  input  wire epnl_pkg::dp_cmd_t cmd,
  input  wire logic last_flag,
  output epnl_pkg::dp_sts_t sts,
  output epnl_pkg::out_item_t rslt
);

  localparam int AW = (MAX_EDGELS > 1) ? $clog2(MAX_EDGELS) : 1;

  logic [9:0] line_mem [MAX_EDGELS];
  logic [13:0] x_mem [MAX_EDGELS];
  logic [12:0] y_mem [MAX_EDGELS];
  logic [15:0] dx_mem [MAX_EDGELS];
  logic [15:0] dy_mem [MAX_EDGELS];

  logic [MAX_EDGELS-1:0] lval, rval;
  logic [5:0] lidx [MAX_EDGELS];
  logic [16:0] lw [MAX_EDGELS];
  logic [5:0] ridx [MAX_EDGELS];
  logic [16:0] rw [MAX_EDGELS];

  logic [9:0] li, lj;
  logic [13:0] xi, xj;
  logic [12:0] yi, yj;
  logic [15:0] axi, ayi, bxj, byj;

  logic found;
  logic [16:0] smax;
  logic [5:0] jmax;
  logic [9:0] line_jmax;

  logic sim_done;
  logic [16:0] score;
  logic [AW-1:0] ia, ja;
  logic [5:0] lft, rgt;
  logic [16:0] lw_rd, rw_rd;
  logic rslt_ready;

  assign ia = cmd.i[AW-1:0];
  assign ja = cmd.j[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      line_mem[load_addr[AW-1:0]] <= in_item.scan_line;
      x_mem[load_addr[AW-1:0]] <= in_item.pos_x;
      y_mem[load_addr[AW-1:0]] <= in_item.pos_y;
      dx_mem[load_addr[AW-1:0]] <= in_item.dir_x;
      dy_mem[load_addr[AW-1:0]] <= in_item.dir_y;
    end
    if (cmd.rd_pair) begin
      li <= line_mem[ia];
      xi <= x_mem[ia];
      yi <= y_mem[ia];
      axi <= dx_mem[ia];
      ayi <= dy_mem[ia];
      lj <= line_mem[ja];
      xj <= x_mem[ja];
      yj <= y_mem[ja];
      bxj <= dx_mem[ja];
      byj <= dy_mem[ja];
    end
  end

  assign sts.adjacent = ({1'b0, lj} == {1'b0, li} + 11'd1) ||
                        ({1'b0, li} == {1'b0, lj} + 11'd1);

  epnl_sim u_sim (
    .clk(clk),
    .rst(rst),
    .start(cmd.sim_start),
    .ax(axi),
    .ay(ayi),
    .bx(bxj),
    .by(byj),
    .dx($signed({1'b0, xj}) - $signed({1'b0, xi})),
    .dy($signed({1'b0, yj}) - $signed({1'b0, yi})),
    .done(sim_done),
    .score(score)
  );
  assign sts.sim_done = sim_done;

  assign lft = (lj < li) ? cmd.j : cmd.i;
  assign rgt = (lj < li) ? cmd.i : cmd.j;

  // link weights fetched while the similarity unit runs
  always_ff @(posedge clk) begin
    lw_rd <= lw[rgt[AW-1:0]];
    rw_rd <= rw[lft[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_links) begin
      lval <= '0;
      rval <= '0;
    end else if (cmd.upd_link && score > match_threshold) begin
      if (!lval[rgt[AW-1:0]] || lw_rd < score) begin
        lval[rgt[AW-1:0]] <= 1'b1;
        lidx[rgt[AW-1:0]] <= lft;
        lw[rgt[AW-1:0]] <= score;
      end
      if (!rval[lft[AW-1:0]] || rw_rd < score) begin
        rval[lft[AW-1:0]] <= 1'b1;
        ridx[lft[AW-1:0]] <= rgt;
        rw[lft[AW-1:0]] <= score;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      found <= 1'b0;
      smax <= '0;
      jmax <= '0;
    end else if (cmd.upd_link && score > smax) begin
      found <= 1'b1;
      smax <= score;
      jmax <= cmd.j;
      line_jmax <= lj;
    end
  end

  assign sts.rslt_ready = rslt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rslt_ready <= 1'b0;
    end else begin
      rslt_ready <= cmd.rd_rslt;
    end
    if (cmd.rd_rslt) begin
      rslt.edgel_index <= cmd.i;
      rslt.last_result <= last_flag;
      if (found && smax > match_threshold) begin
        rslt.pair_valid <= 1'b1;
        rslt.pair_score <= smax;
        rslt.pair_left <= (li < line_jmax) ? cmd.i : jmax;
        rslt.pair_right <= (li < line_jmax) ? jmax : cmd.i;
      end else begin
        rslt.pair_valid <= 1'b0;
        rslt.pair_score <= '0;
        rslt.pair_left <= '0;
        rslt.pair_right <= '0;
      end
      rslt.has_left <= lval[ia];
      rslt.left_index <= lval[ia] ? lidx[ia] : 6'd0;
      rslt.left_weight <= lval[ia] ? lw[ia] : 17'd0;
      rslt.has_right <= rval[ia];
      rslt.right_index <= rval[ia] ? ridx[ia] : 6'd0;
      rslt.right_weight <= rval[ia] ? rw[ia] : 17'd0;
    end
  end

endmodule
`default_nettype wire

// ----- design/epnl_ctrl.sv -----
//------------------------------------------------------------------------------
// epnl_ctrl
// sequencer for load, pair scan and result output
//------------------------------------------------------------------------------
`default_nettype none
module epnl_ctrl #(
  parameter int MAX_EDGELS = epnl_pkg::MaxEdgelsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic in_last,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [5:0] load_addr,
  output logic last_flag,
  output epnl_pkg::dp_cmd_t cmd,
  input  wire epnl_pkg::dp_sts_t sts
);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_ROW = 4'd1;
  localparam logic [3:0] S_RD = 4'd2;
  localparam logic [3:0] S_CHK = 4'd3;
  localparam logic [3:0] S_WAIT = 4'd4;
  localparam logic [3:0] S_NEXT = 4'd5;
  localparam logic [3:0] S_ORD = 4'd6;
  localparam logic [3:0] S_OUT = 4'd7;
  localparam logic [3:0] S_CLR = 4'd8;

  logic [3:0] state;
  logic [6:0] count;
  logic [6:0] i, j;
  logic accept;

  assign in_ready = (state == S_LOAD);
  assign accept = in_valid && in_ready;
  assign load_addr = count[5:0];
  assign last_flag = (i + 7'd1 == count);

  always_comb begin
    cmd = '0;
    cmd.i = i[5:0];
    cmd.j = j[5:0];
    cmd.load = accept && (count < 7'(MAX_EDGELS));
    cmd.clear_links = (state == S_CLR);
    cmd.clear_step = (state == S_ROW);
    cmd.rd_pair = (state == S_RD);
    cmd.sim_start = (state == S_CHK) && sts.adjacent;
    cmd.upd_link = (state == S_WAIT) && sts.sim_done;
    cmd.rd_rslt = (state == S_ORD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      i <= '0;
      j <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (count < 7'(MAX_EDGELS)) count <= count + 7'd1;
            if (in_last) state <= S_CLR;
          end
        end
        S_CLR: begin
          i <= '0;
          state <= S_ROW;
        end
        S_ROW: begin
          j <= i + 7'd1;
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (j < count) state <= S_RD;
          else state <= S_ORD;
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (sts.adjacent) begin
            state <= S_WAIT;
          end else begin
            j <= j + 7'd1;
            state <= S_NEXT;
          end
        end
        S_WAIT: begin
          if (sts.sim_done) begin
            j <= j + 7'd1;
            state <= S_NEXT;
          end
        end
        S_ORD: state <= S_OUT;
        S_OUT: begin
          if (sts.rslt_ready) out_valid <= 1'b1;
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            if (last_flag) begin
              count <= '0;
              state <= S_LOAD;
            end else begin
              i <= i + 7'd1;
              state <= S_ROW;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/edgel_pair_neighbor_linker.sv -----
//------------------------------------------------------------------------------
// edgel_pair_neighbor_linker
// links edgels on adjacent scan lines into best pairs and neighbor chains
//------------------------------------------------------------------------------
// Edgels load one per cycle while the block is in its load phase. The
// transaction with last_edgel starts a scan of every pair i<j; each pair on
// adjacent lines goes through the similarity unit (products, a 24-step root
// and a bit-serial divide, both skipped when the dot product of the directions
// is not positive or the positions coincide). One result per stored edgel
// follows after its row; no edgel is taken until the set's last result is taken.
`default_nettype none
module edgel_pair_neighbor_linker #(
  parameter int MAX_EDGELS = epnl_pkg::MaxEdgelsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [16:0] cfg_wdata,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire epnl_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output epnl_pkg::out_item_t out_data
);

  logic [16:0] match_threshold;
  epnl_pkg::dp_cmd_t cmd;
  epnl_pkg::dp_sts_t sts;
  logic [5:0] load_addr;
  logic last_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_threshold <= epnl_pkg::ThresholdReset;
    end else if (cfg_we) begin
      match_threshold <= cfg_wdata;
    end
  end

  epnl_ctrl #(.MAX_EDGELS(MAX_EDGELS)) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_last(in_data.last_edgel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .load_addr(load_addr),
    .last_flag(last_flag),
    .cmd(cmd),
    .sts(sts)
  );

  epnl_dp #(.MAX_EDGELS(MAX_EDGELS)) u_dp (
    .clk(clk),
    .rst(rst),
    .in_item(in_data),
    .load_addr(load_addr),
    .match_threshold(match_threshold),
    .cmd(cmd),
    .last_flag(last_flag),
    .sts(sts),
    .rslt(out_data)
  );

endmodule
`default_nettype wire

// ----- tb/tb_edgel_pair_neighbor_linker.sv -----
//------------------------------------------------------------------------------
// tb_edgel_pair_neighbor_linker
// loads edgel sets, predicts pair and neighbor links per edgel and compares
// every result transaction as a whole against the prediction
//------------------------------------------------------------------------------
`default_nettype none
module tb_edgel_pair_neighbor_linker;

  localparam int WatchdogLimit = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  epnl_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  epnl_pkg::out_item_t out_data;

  edgel_pair_neighbor_linker i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [16:0] thresh_q = epnl_pkg::ThresholdReset;
  int stored_cnt = 0;
  logic [9:0] line_m [64];
  longint px_m [64], py_m [64], dx_m [64], dy_m [64];
  epnl_pkg::out_item_t expected_q [$];

  int mismatches = 0;
  int results_seen = 0;
  int sets_done = 0;
  int idle_pct = 25;
  bit rx_hold = 1'b0;
  int stall_cycles = 0;

  function automatic longint iroot(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint labs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint pair_similarity(int a, int b);
    longint dot, ddx, ddy, c, ln, d;
    dot = dx_m[a] * dx_m[b] + dy_m[a] * dy_m[b];
    if (dot <= 0) return 0;
    ddx = px_m[b] - px_m[a];
    ddy = py_m[b] - py_m[a];
    if (ddx == 0 && ddy == 0) return 65536;
    c = labs(dx_m[a] * ddy - dy_m[a] * ddx) + labs(dx_m[b] * ddy - dy_m[b] * ddx);
    ln = iroot((ddx * ddx + ddy * ddy) <<< 16);
    d = ((c <<< 9) + ln / 2) / ln;
    if (d >= 65536) return 0;
    return 65536 - d;
  endfunction

  task automatic predict_links();
    epnl_pkg::out_item_t r [64];
    int i, j, jbest, lft, rgt;
    longint s, sbest;
    bit found;
    for (i = 0; i < stored_cnt; i++) r[i] = '0;
    for (i = 0; i < stored_cnt; i++) begin
      found = 0;
      jbest = 0;
      sbest = 0;
      for (j = i + 1; j < stored_cnt; j++) begin
        if (!(int'(line_m[j]) == int'(line_m[i]) + 1 ||
              int'(line_m[i]) == int'(line_m[j]) + 1)) continue;
        s = pair_similarity(i, j);
        if (s > sbest) begin
          sbest = s;
          jbest = j;
          found = 1;
        end
        if (s > thresh_q) begin
          lft = (line_m[j] < line_m[i]) ? j : i;
          rgt = (line_m[j] < line_m[i]) ? i : j;
          if (!r[rgt].has_left || r[rgt].left_weight < s) begin
            r[rgt].has_left = 1'b1;
            r[rgt].left_index = 6'(lft);
            r[rgt].left_weight = 17'(s);
          end
          if (!r[lft].has_right || r[lft].right_weight < s) begin
            r[lft].has_right = 1'b1;
            r[lft].right_index = 6'(rgt);
            r[lft].right_weight = 17'(s);
          end
        end
      end
      if (found && sbest > thresh_q) begin
        r[i].pair_valid = 1'b1;
        r[i].pair_score = 17'(sbest);
        r[i].pair_left = 6'((line_m[i] < line_m[jbest]) ? i : jbest);
        r[i].pair_right = 6'((line_m[i] < line_m[jbest]) ? jbest : i);
      end
    end
    for (i = 0; i < stored_cnt; i++) begin
      r[i].edgel_index = 6'(i);
      r[i].last_result = (i + 1 == stored_cnt);
      expected_q.insert(expected_q.size(), r[i]);
    end
    stored_cnt = 0;
  endtask

  task automatic accept_edgel(epnl_pkg::in_item_t e);
    if (stored_cnt < 64) begin
      line_m[stored_cnt] = e.scan_line;
      px_m[stored_cnt] = e.pos_x;
      py_m[stored_cnt] = e.pos_y;
      dx_m[stored_cnt] = e.dir_x;
      dy_m[stored_cnt] = e.dir_y;
      stored_cnt++;
    end
    if (e.last_edgel) predict_links();
  endtask

  task automatic send_edgel(epnl_pkg::in_item_t e);
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accept_edgel(e);
  endtask

  // drop valid after the last transaction of a burst
  task automatic end_input();
    in_valid <= 1'b0;
  endtask

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (idle_pct == 0) || ($urandom_range(99, 0) >= idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    epnl_pkg::out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", out_data);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", exp_r, out_data);
        end
      end
    end
  end

  // watchdog
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst || rx_hold) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog expired");
      $display("tb_edgel_pair_neighbor_linker NOT OK");
      $finish;
    end
  end

  function automatic epnl_pkg::in_item_t rand_edgel(int base_line, bit is_last);
    epnl_pkg::in_item_t e;
    int ang;
    e.scan_line = 10'(base_line + int'($urandom_range(1, 0)));
    e.pos_x = 14'($urandom_range(10239, 0));
    e.pos_y = 13'($urandom_range(7679, 0));
    ang = int'($urandom_range(3, 0));
    if ($urandom_range(9, 0) == 0) begin
      e.dir_x = 16'($urandom);
      e.dir_y = 16'($urandom);
    end else begin
      e.dir_x = 16'(int'($urandom_range(16384, 0)) * ((ang & 1) ? -1 : 1));
      e.dir_y = 16'(int'($urandom_range(16384, 0)) * ((ang & 2) ? -1 : 1));
    end
    e.last_edgel = is_last;
    return e;
  endfunction

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic wait_results();
    end_input();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(logic [16:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    thresh_q = v;
  endtask

  // nearly collinear edgels along a line so that links form
  task automatic send_chain(int n, int base_line);
    epnl_pkg::in_item_t e;
    int k;
    for (k = 0; k < n; k++) begin
      e.scan_line = 10'(base_line + k);
      e.pos_x = 14'(100 + k * 32 + int'($urandom_range(3, 0)));
      e.pos_y = 13'(200 + int'($urandom_range(3, 0)));
      e.dir_x = 16'(16384 - int'($urandom_range(50, 0)));
      e.dir_y = 16'($urandom_range(200, 0));
      e.last_edgel = (k == n - 1);
      send_edgel(e);
    end
  endtask

  task automatic test_directed();
    epnl_pkg::in_item_t e;
    e = '0;
    e.dir_x = 16'sd16384;
    send_edgel(e);
    e.scan_line = 10'd1;
    send_edgel(e);
    e.scan_line = 10'd1023;
    e.pos_x = 14'd10239;
    e.pos_y = 13'd7679;
    e.dir_x = -16'sd16384;
    e.dir_y = -16'sd16384;
    send_edgel(e);
    e.scan_line = 10'd1022;
    e.dir_x = 16'sd16384;
    e.dir_y = 16'sd16384;
    send_edgel(e);
    e.scan_line = 10'd2;
    e.pos_x = '0;
    e.pos_y = '0;
    e.dir_x = 16'sh7fff;
    e.dir_y = 16'sh8000;
    e.last_edgel = 1'b1;
    send_edgel(e);
    e.last_edgel = 1'b1;
    e.scan_line = 10'd5;
    send_edgel(e);
    send_chain(6, 10);
    end_input();
    wait_drained();
  endtask

  task automatic test_thresholds();
    write_threshold(17'd0);
    send_chain(5, 0);
    end_input();
    wait_drained();
    write_threshold(epnl_pkg::ScoreOne);
    send_chain(4, 0);
    end_input();
    wait_drained();
    write_threshold(17'h1ffff);
    send_chain(3, 0);
    end_input();
    wait_drained();
    write_threshold(17'd60000);
    send_chain(4, 300);
    end_input();
    wait_drained();
  endtask

  task automatic test_full_store();
    int k;
    for (k = 0; k < 66; k++) send_edgel(rand_edgel(k / 3, k == 65));
    end_input();
    wait_drained();
  endtask

  task automatic test_backpressure();
    int k;
    rx_hold = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        rx_hold = 1'b0;
      end
      begin
        for (k = 0; k < 8; k++) send_edgel(rand_edgel(50, k == 7 || k == 3));
        end_input();
      end
    join
    wait_drained();
  endtask

  task automatic test_random(int target);
    int sent, n, k, base;
    sent = 0;
    while (sent < target) begin
      if (sent > target / 2 && sent < target / 2 + 60) idle_pct = 0;
      else idle_pct = 25;
      if ($urandom_range(3, 0) == 0) write_threshold(17'($urandom_range(65536, 40000)));
      n = int'($urandom_range(8, 1));
      base = int'($urandom_range(1020, 0));
      if ($urandom_range(4, 0) == 0) begin
        send_chain(n + 1, base);
        sent += n + 1;
      end else begin
        for (k = 0; k < n; k++) send_edgel(rand_edgel(base, k == n - 1));
        sent += n;
      end
      wait_results();
      if ($urandom_range(9, 0) == 0) wait_drained();
      sets_done++;
    end
    idle_pct = 25;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_thresholds();
    test_full_store();
    test_backpressure();
    test_random(250);
    wait_drained();
    $display("covered %0d random edgel sets and %0d result transactions", sets_done,
             results_seen);
    $display("thresholds 0, 65536 and above, full store drop and long output stall");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb_edgel_pair_neighbor_linker OK");
    end else begin
      $display("tb_edgel_pair_neighbor_linker NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
design/epnl_pkg.sv
design/epnl_sim.sv
design/epnl_dp.sv
design/epnl_ctrl.sv
design/edgel_pair_neighbor_linker.sv
tb/tb_edgel_pair_neighbor_linker.sv
